/* hdl/accumulator_cpu_8bit_step_core_defines.svh */
// Assertion macros shared by the block's modules.
// No dependencies.
`ifndef ACCUMULATOR_CPU_8BIT_STEP_CORE_DEFINES_SVH
`define ACCUMULATOR_CPU_8BIT_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ACS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ACS_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ACS_ASSERT(label, clk, rst, prop)
`define ACS_ASSERT_R(label, clk, prop)
`endif
`endif

/* hdl/acs_pkg.sv */
// Package of the accumulator CPU step core: item kinds, opcode groups, queue entry
// and status codes. No dependencies.
package acs_pkg;

  localparam int MemBytes = 512;
  localparam int MemAddrW = 9;

  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindExec  = 2'd2;

  localparam logic [1:0] StRun     = 2'd0;
  localparam logic [1:0] StHalt    = 2'd1;
  localparam logic [1:0] StIllegal = 2'd2;

  localparam logic [3:0] OpMisc   = 4'h0;
  localparam logic [3:0] OpIo     = 4'h1;
  localparam logic [3:0] OpFlag   = 4'h2;
  localparam logic [3:0] OpBranch = 4'h3;
  localparam logic [3:0] OpShift  = 4'h4;
  localparam logic [3:0] OpBad    = 4'h5;
  localparam logic [3:0] OpLd     = 4'h6;
  localparam logic [3:0] OpSt     = 4'h7;
  localparam logic [3:0] OpSbc    = 4'h8;
  localparam logic [3:0] OpAdc    = 4'h9;
  localparam logic [3:0] OpSub    = 4'ha;
  localparam logic [3:0] OpAdd    = 4'hb;
  localparam logic [3:0] OpEor    = 4'hc;
  localparam logic [3:0] OpOr     = 4'hd;
  localparam logic [3:0] OpAnd    = 4'he;
  localparam logic [3:0] OpCmp    = 4'hf;

  localparam logic [7:0] IrIllegal = 8'h08;
  localparam logic [7:0] IrJal     = 8'h0a;
  localparam logic [7:0] IrJr      = 8'h0b;
  localparam logic [7:0] IrHalt    = 8'h0c;

  typedef struct packed {
    logic [1:0]          kind;
    logic [MemAddrW-1:0] mem_addr;
    logic [7:0]          mem_wdata;
    logic [7:0]          in_data;
    logic                in_full;
    logic                out_drained;
  } item_t;

endpackage

/* hdl/acs_front.sv */
// Front part: accepts input beats and queues them in a two-entry queue.
// Depends on acs_pkg and the defines header.
`include "accumulator_cpu_8bit_step_core_defines.svh"
module acs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  acs_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_take,
  output acs_pkg::item_t q_item
);

  acs_pkg::item_t slots [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign pop = q_take && q_valid;
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ACS_ASSERT(a_no_overflow, clk, rst, count <= 2'd2)
  `ACS_ASSERT(a_push_counts, clk, rst, (push && !pop && count == 2'd0) |=> count == 2'd1)
  `ACS_ASSERT(a_ptr_gap, clk, rst, (count == 2'd1) |-> (rd_ptr != wr_ptr))

endmodule

/* hdl/acs_back.sv */
// Back part: executes queued items against the CPU state and a 512-byte memory.
// Depends on acs_pkg and the defines header.
`include "accumulator_cpu_8bit_step_core_defines.svh"
module acs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  acs_pkg::item_t q_item,
  output logic           valid,
  input  logic           stall,
  output logic [1:0]     status,
  output logic [7:0]     mem_rdata,
  output logic [7:0]     out_data,
  output logic           out_strobe,
  output logic           in_taken,
  output logic [7:0]     prog_counter,
  output logic [7:0]     accumulator,
  output logic [7:0]     index_reg,
  output logic [3:0]     flag_bits
);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DECODE, S_WORD, S_OPER, S_DONE
  } state_t;

  logic [7:0] mem [acs_pkg::MemBytes];
  logic [7:0] rdata;
  logic       mem_we;
  logic [acs_pkg::MemAddrW-1:0] mem_ra;
  logic [acs_pkg::MemAddrW-1:0] mem_wa;
  logic [7:0] mem_wd;

  state_t state;
  acs_pkg::item_t cur;
  logic [7:0] pc;
  logic [7:0] acc;
  logic [7:0] ix;
  logic [3:0] flags;
  logic       out_full;
  logic [1:0] halt;
  logic [7:0] ir;
  logic [7:0] word2;

  logic out_free;
  logic [7:0] op_a;
  logic [7:0] w_src;
  logic [acs_pkg::MemAddrW-1:0] ea;
  logic [7:0] opb;
  logic [8:0] sum;
  logic [7:0] res;
  logic [3:0] fl_alu;
  logic [7:0] sh_r;
  logic       sh_c;
  logic       sh_v;
  logic       go;
  logic       cin;
  logic       v_n;
  logic       needs_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  assign out_free = !valid || !stall;
  assign op_a = ir[3] ? ix : acc;
  assign w_src = (state == S_WORD) ? rdata : word2;
  assign ea = {ir[0], ir[1] ? (w_src + ix) : w_src};
  assign opb = (ir[2:0] == 3'd0) ? acc : (ir[2:0] == 3'd1) ? ix :
               (ir[2:0] < 3'd4) ? word2 : rdata;
  assign cin = flags[3];
  assign v_n = flags[2] ^ flags[1];
  assign needs_word = (ir[7:4] == acs_pkg::OpBranch) || (ir[7:4] == acs_pkg::OpSt) ||
                      (ir == acs_pkg::IrJal) ||
                      (ir[7:4] >= acs_pkg::OpLd && ir[2:0] >= 3'd2);
  assign q_take = (state == S_IDLE) && q_valid;

  always_comb begin
    unique case (ir[3:0])
      4'h0: go = 1'b1;
      4'h1: go = !flags[0];
      4'h2: go = !flags[1];
      4'h3: go = !(flags[1] | flags[0]);
      4'h4: go = !cur.in_full;
      4'h5: go = !flags[3];
      4'h6: go = !v_n;
      4'h7: go = !(v_n | flags[0]);
      4'h8: go = flags[2];
      4'h9: go = flags[0];
      4'ha: go = flags[1];
      4'hb: go = flags[1] | flags[0];
      4'hc: go = out_full;
      4'hd: go = flags[3];
      4'he: go = v_n;
      default: go = v_n | flags[0];
    endcase
  end

  always_comb begin
    sh_v = 1'b0;
    if (!ir[0]) begin
      sh_c = op_a[0];
      sh_r = {1'b0, op_a[7:1]};
      if (!ir[2] && !ir[1]) sh_r[7] = op_a[7];
      if (ir[2] && !ir[1]) sh_r[7] = cin;
      if (ir[2] && ir[1]) sh_r[7] = op_a[0];
    end else begin
      sh_c = op_a[7];
      sh_r = {op_a[6:0], 1'b0};
      if (ir[2] && !ir[1]) sh_r[0] = cin;
      if (ir[2] && ir[1]) sh_r[0] = sh_c;
      if (!ir[1]) sh_v = op_a[7] ^ sh_r[7];
    end
  end

  always_comb begin
    fl_alu = flags;
    sum = 9'd0;
    res = opb;
    unique case (ir[7:4])
      acs_pkg::OpSbc, acs_pkg::OpSub, acs_pkg::OpCmp: begin
        sum = {1'b0, op_a} - {1'b0, opb} - {8'd0, (ir[7:4] == acs_pkg::OpSbc) & cin};
        res = sum[7:0];
        fl_alu[2] = (op_a[7] ^ opb[7]) & (op_a[7] ^ res[7]);
        if (ir[7:4] == acs_pkg::OpSbc) fl_alu[3] = sum[8];
      end
      acs_pkg::OpAdc, acs_pkg::OpAdd: begin
        sum = {1'b0, op_a} + {1'b0, opb} + {8'd0, (ir[7:4] == acs_pkg::OpAdc) & cin};
        res = sum[7:0];
        fl_alu[2] = !(op_a[7] ^ opb[7]) & (op_a[7] ^ res[7]);
        if (ir[7:4] == acs_pkg::OpAdc) fl_alu[3] = sum[8];
      end
      acs_pkg::OpEor: begin
        res = op_a ^ opb;
        fl_alu[2] = 1'b0;
      end
      acs_pkg::OpOr: begin
        res = op_a | opb;
        fl_alu[2] = 1'b0;
      end
      acs_pkg::OpAnd: begin
        res = op_a & opb;
        fl_alu[2] = 1'b0;
      end
      default: begin
        res = opb;
      end
    endcase
    if (ir[7:4] != acs_pkg::OpLd) begin
      fl_alu[1] = res[7];
      fl_alu[0] = (res == 8'd0);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = q_item.mem_addr;
    mem_wd = q_item.mem_wdata;
    mem_ra = q_item.mem_addr;
    unique case (state)
      S_IDLE: begin
        mem_we = q_valid && (q_item.kind == acs_pkg::KindWrite);
      end
      S_FETCH: begin
        mem_ra = {1'b0, pc};
      end
      S_DECODE: begin
        mem_ra = {1'b0, pc + 8'd1};
      end
      S_WORD: begin
        mem_ra = ea;
        mem_wa = ea;
        mem_wd = op_a;
        mem_we = (ir[7:4] == acs_pkg::OpSt) && ir[2];
      end
      S_DONE: begin
        mem_ra = cur.mem_addr;
      end
      default: begin
        mem_ra = ea;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      pc <= 8'd0;
      acc <= 8'd0;
      ix <= 8'd0;
      flags <= 4'd0;
      out_full <= 1'b0;
      halt <= acs_pkg::StRun;
    end else begin
      if (valid && !stall && state != S_DONE) begin
        valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.out_drained) out_full <= 1'b0;
            if (q_item.kind == acs_pkg::KindExec && halt == acs_pkg::StRun) begin
              state <= S_FETCH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FETCH: begin
          state <= S_DECODE;
        end
        S_DECODE: begin
          ir <= rdata;
          pc <= pc + 8'd1;
          state <= S_WORD;
        end
        S_WORD: begin
          if (needs_word) begin
            word2 <= rdata;
            pc <= pc + 8'd1;
          end
          state <= S_OPER;
        end
        S_OPER: begin
          state <= S_DONE;
        end
        default: begin
          if (out_free) begin
            state <= S_IDLE;
            valid <= 1'b1;
            status <= halt;
            mem_rdata <= (cur.kind == acs_pkg::KindRead) ? rdata : 8'd0;
            prog_counter <= pc;
            accumulator <= acc;
            index_reg <= ix;
            flag_bits <= flags;
          end
        end
      endcase
      if (state == S_OPER) begin
        unique case (ir[7:4])
          acs_pkg::OpMisc: begin
            if (ir == acs_pkg::IrJal) begin
              acc <= pc;
              pc <= word2;
            end else if (ir == acs_pkg::IrJr) begin
              pc <= acc;
            end else if (ir >= acs_pkg::IrHalt) begin
              halt <= acs_pkg::StHalt;
            end else if (ir >= acs_pkg::IrIllegal) begin
              halt <= acs_pkg::StIllegal;
            end
          end
          acs_pkg::OpIo: begin
            if (ir[3]) begin
              acc <= cur.in_data;
            end else begin
              out_full <= 1'b1;
            end
          end
          acs_pkg::OpFlag: flags[3] <= ir[3];
          acs_pkg::OpBranch: if (go) pc <= word2;
          acs_pkg::OpShift: begin
            flags <= {sh_c, sh_v, sh_r[7], sh_r == 8'd0};
            if (ir[3]) ix <= sh_r; else acc <= sh_r;
          end
          acs_pkg::OpBad: halt <= acs_pkg::StIllegal;
          acs_pkg::OpSt: if (!ir[2]) halt <= acs_pkg::StIllegal;
          default: begin
            flags <= fl_alu;
            if (ir[7:4] != acs_pkg::OpCmp) begin
              if (ir[3]) ix <= res; else acc <= res;
            end
          end
        endcase
      end
    end
  end

  logic strobe_p;
  logic taken_p;
  logic [7:0] odata_p;

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      strobe_p <= 1'b0;
      taken_p <= 1'b0;
      odata_p <= 8'd0;
    end else if (state == S_OPER && ir[7:4] == acs_pkg::OpIo) begin
      strobe_p <= !ir[3];
      taken_p <= ir[3];
      odata_p <= ir[3] ? 8'd0 : acc;
    end
    if (state == S_DONE && out_free && !rst) begin
      out_strobe <= strobe_p;
      in_taken <= taken_p;
      out_data <= odata_p;
    end
  end

  `ACS_ASSERT(a_no_drop, clk, rst, (valid && stall) |=> valid)
  `ACS_ASSERT(a_take_idle, clk, rst, q_take |-> (state == S_IDLE))
  `ACS_ASSERT(a_halt_sticky, clk, rst, (halt != acs_pkg::StRun) |=> (halt == $past(halt)))
  `ACS_ASSERT(a_strobe_excl, clk, rst, valid |-> !(out_strobe && in_taken))

endmodule

/* hdl/accumulator_cpu_8bit_step_core.sv */
// Top level of the 8-bit accumulator CPU step core.
// Uses acs_pkg, acs_front and acs_back.
//
// Input channel: valid/stall carrying one item (memory write, memory read
// or execute one instruction). Output channel: valid/stall carrying one
// result beat per item, in order.
// A memory write or read item passes from the queue through the idle and done
// states to its result beat; an instruction also passes through the fetch,
// decode, second-word and operand states for its fetch, second-word and operand
// reads through the single memory read port. The back part takes a new item
// only when idle, after it has presented the last item's result beat; a two-entry
// queue lets the input side accept beats back to back while the back part executes.
// Reset clears PC, ACC, IX, flags, output-full flag and halt status; the
// memory is not cleared and must be written before it is read.
// When the receiver stalls, the result beat holds and the back part waits;
// the queue then fills and stall is raised on the input side.
module accumulator_cpu_8bit_step_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [8:0] mem_addr,
  input  logic [7:0] mem_wdata,
  input  logic [7:0] in_data,
  input  logic       in_full,
  input  logic       out_drained,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] mem_rdata,
  output logic [7:0] out_data,
  output logic       out_strobe,
  output logic       in_taken,
  output logic [7:0] prog_counter,
  output logic [7:0] accumulator,
  output logic [7:0] index_reg,
  output logic [3:0] flag_bits
);

  acs_pkg::item_t in_item;
  acs_pkg::item_t q_item;
  logic q_valid;
  logic q_take;

  assign in_item = '{kind: kind, mem_addr: mem_addr, mem_wdata: mem_wdata,
                     in_data: in_data, in_full: in_full, out_drained: out_drained};

  acs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  acs_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .valid(out_valid), .stall(out_stall), .status(status), .mem_rdata(mem_rdata),
    .out_data(out_data), .out_strobe(out_strobe), .in_taken(in_taken),
    .prog_counter(prog_counter), .accumulator(accumulator),
    .index_reg(index_reg), .flag_bits(flag_bits)
  );

endmodule

/* tb/accumulator_cpu_8bit_step_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the accumulator CPU step core: it loads memory,
// runs directed and random instructions and checks every result beat.
// Depends on acs_pkg and accumulator_cpu_8bit_step_core.
module accumulator_cpu_8bit_step_core_tb;

  localparam logic [1:0] KindNone = 2'd3;
  localparam int WatchLimit = 3000;
  localparam int HoldStart = 200;
  localparam int HoldLen = 300;
  localparam int QuietStart = 700;
  localparam int QuietEnd = 1100;

  typedef struct packed {
    logic [1:0] st;
    logic [7:0] rd;
    logic [7:0] od;
    logic       os;
    logic       it;
    logic [7:0] pc;
    logic [7:0] ac;
    logic [7:0] ix;
    logic [3:0] fl;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = acs_pkg::KindWrite;
  logic [8:0] mem_addr = '0;
  logic [7:0] mem_wdata = '0;
  logic [7:0] in_data = '0;
  logic in_full = 1'b0;
  logic out_drained = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] mem_rdata, out_data, prog_counter, accumulator, index_reg;
  logic out_strobe, in_taken;
  logic [3:0] flag_bits;

  accumulator_cpu_8bit_step_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  acs_pkg::item_t pending[$];
  beat_t expected_beats[$];
  int errors = 0;
  int cycle = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;

  // Predicted CPU state.
  logic [7:0] cpu_pc = '0, cpu_acc = '0, cpu_ix = '0;
  logic [3:0] cpu_flags = '0;
  logic cpu_ofull = 1'b0;
  logic [1:0] cpu_halt = acs_pkg::StRun;
  logic [7:0] cpu_mem [acs_pkg::MemBytes];

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = cpu_mem[cpu_pc];
    cpu_pc = cpu_pc + 8'd1;
    return b;
  endfunction

  function automatic logic [8:0] data_addr(logic [2:0] mode, logic [7:0] w);
    logic [8:0] a;
    a = {1'b0, mode[1] ? w + cpu_ix : w};
    if (mode[0]) a[8] = 1'b1;
    return a;
  endfunction

  function automatic void set_nz(logic [7:0] r);
    cpu_flags[1] = r[7];
    cpu_flags[0] = (r == 8'd0);
  endfunction

  function automatic logic branch_taken(logic [3:0] cc, logic ifull);
    logic v, n, z, c;
    {c, v, n, z} = cpu_flags;
    case (cc)
      4'h0: return 1'b1;
      4'h1: return !z;
      4'h2: return !n;
      4'h3: return !(n | z);
      4'h4: return !ifull;
      4'h5: return !c;
      4'h6: return !(v ^ n);
      4'h7: return !((v ^ n) | z);
      4'h8: return v;
      4'h9: return z;
      4'ha: return n;
      4'hb: return n | z;
      4'hc: return cpu_ofull;
      4'hd: return c;
      4'he: return v ^ n;
      default: return (v ^ n) | z;
    endcase
  endfunction

  function automatic void run_insn(acs_pkg::item_t it, ref beat_t e);
    logic [7:0] ir, a, b, t, r;
    logic [3:0] hi;
    logic [2:0] mode;
    logic [8:0] wide;
    logic c, cin, v;
    ir = fetch_byte();
    hi = ir[7:4];
    mode = ir[2:0];
    a = ir[3] ? cpu_ix : cpu_acc;
    case (hi)
      acs_pkg::OpMisc: begin
        if (ir < acs_pkg::IrIllegal) return;
        if (ir == acs_pkg::IrJal) begin
          t = fetch_byte();
          cpu_acc = cpu_pc;
          cpu_pc = t;
        end else if (ir == acs_pkg::IrJr) begin
          cpu_pc = cpu_acc;
        end else begin
          cpu_halt = (ir >= acs_pkg::IrHalt) ? acs_pkg::StHalt : acs_pkg::StIllegal;
        end
        return;
      end
      acs_pkg::OpIo: begin
        if (ir[3]) begin
          cpu_acc = it.in_data;
          e.it = 1'b1;
        end else begin
          e.od = cpu_acc;
          e.os = 1'b1;
          cpu_ofull = 1'b1;
        end
        return;
      end
      acs_pkg::OpFlag: begin
        cpu_flags[3] = ir[3];
        return;
      end
      acs_pkg::OpBranch: begin
        t = fetch_byte();
        if (branch_taken(ir[3:0], it.in_full)) cpu_pc = t;
        return;
      end
      acs_pkg::OpShift: begin
        cin = cpu_flags[3];
        v = 1'b0;
        if (!ir[0]) begin
          c = a[0];
          r = a >> 1;
          if (ir[1:0] == 2'd0) r[7] = ir[2] ? cin : a[7];
          else if (ir[2]) r[7] = a[0];
        end else begin
          c = a[7];
          r = a << 1;
          if (ir[2]) r[0] = (ir[1:0] == 2'd1) ? cin : c;
          if (ir[1:0] == 2'd1) v = a[7] ^ r[7];
        end
        cpu_flags[3] = c;
        cpu_flags[2] = v;
        set_nz(r);
        if (ir[3]) cpu_ix = r; else cpu_acc = r;
        return;
      end
      acs_pkg::OpBad: begin
        cpu_halt = acs_pkg::StIllegal;
        return;
      end
      acs_pkg::OpSt: begin
        t = fetch_byte();
        if (mode < 3'd4) cpu_halt = acs_pkg::StIllegal;
        else cpu_mem[data_addr(mode, t)] = a;
        return;
      end
      default: ;
    endcase
    if (mode == 3'd0) b = cpu_acc;
    else if (mode == 3'd1) b = cpu_ix;
    else if (mode < 3'd4) b = fetch_byte();
    else b = cpu_mem[data_addr(mode, fetch_byte())];
    case (hi)
      acs_pkg::OpLd: r = b;
      acs_pkg::OpSbc, acs_pkg::OpSub, acs_pkg::OpCmp: begin
        cin = (hi == acs_pkg::OpSbc) ? cpu_flags[3] : 1'b0;
        r = a - b - cin;
        cpu_flags[2] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
        if (hi == acs_pkg::OpSbc) cpu_flags[3] = ({1'b0, a} < {1'b0, b} + cin);
        set_nz(r);
        if (hi == acs_pkg::OpCmp) return;
      end
      acs_pkg::OpAdc, acs_pkg::OpAdd: begin
        cin = (hi == acs_pkg::OpAdc) ? cpu_flags[3] : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + cin;
        r = wide[7:0];
        cpu_flags[2] = !(a[7] ^ b[7]) & (a[7] ^ r[7]);
        if (hi == acs_pkg::OpAdc) cpu_flags[3] = wide[8];
        set_nz(r);
      end
      acs_pkg::OpEor: begin r = a ^ b; cpu_flags[2] = 1'b0; set_nz(r); end
      acs_pkg::OpOr: begin r = a | b; cpu_flags[2] = 1'b0; set_nz(r); end
      default: begin r = a & b; cpu_flags[2] = 1'b0; set_nz(r); end
    endcase
    if (ir[3]) cpu_ix = r; else cpu_acc = r;
  endfunction

  function automatic void add_item(logic [1:0] k, logic [8:0] addr, logic [7:0] wd);
    acs_pkg::item_t it;
    beat_t e;
    it.kind = k;
    it.mem_addr = addr;
    it.mem_wdata = wd;
    it.in_data = 8'($urandom_range(0, 255));
    it.in_full = 1'($urandom_range(0, 1));
    it.out_drained = 1'($urandom_range(0, 1));
    e = '0;
    if (it.out_drained) cpu_ofull = 1'b0;
    if (k == acs_pkg::KindWrite) cpu_mem[addr] = wd;
    else if (k == acs_pkg::KindRead) e.rd = cpu_mem[addr];
    else if (k == acs_pkg::KindExec && cpu_halt == acs_pkg::StRun) run_insn(it, e);
    e.st = cpu_halt;
    e.pc = cpu_pc;
    e.ac = cpu_acc;
    e.ix = cpu_ix;
    e.fl = cpu_flags;
    pending.push_back(it);
    expected_beats.push_back(e);
  endfunction

  // Places an instruction and its second word at PC, then executes it.
  function automatic void add_insn(logic [7:0] ir, logic [7:0] w);
    add_item(acs_pkg::KindWrite, {1'b0, cpu_pc}, ir);
    add_item(acs_pkg::KindWrite, {1'b0, cpu_pc + 8'd1}, w);
    add_item(acs_pkg::KindExec, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic stops_cpu(logic [7:0] ir);
    return ir == acs_pkg::IrIllegal || ir == acs_pkg::IrIllegal + 8'd1 ||
           (ir >= acs_pkg::IrHalt && ir[7:4] == acs_pkg::OpMisc) ||
           ir[7:4] == acs_pkg::OpBad || (ir[7:4] == acs_pkg::OpSt && ir[2:0] < 3'd4);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic compare(string field, logic [7:0] got, logic [7:0] want);
    if (got !== want) report(field, got, want);
  endtask

  always @(posedge clk) begin
    beat_t e;
    cycle <= cycle + 1;
    in_fire <= !rst && in_valid && !in_stall;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", 8'd0, 8'd0);
      end else begin
        e = expected_beats.pop_front();
        compare("status", {6'd0, status}, {6'd0, e.st});
        compare("mem_rdata", mem_rdata, e.rd);
        compare("out_data", out_data, e.od);
        compare("out_strobe", {7'd0, out_strobe}, {7'd0, e.os});
        compare("in_taken", {7'd0, in_taken}, {7'd0, e.it});
        compare("prog_counter", prog_counter, e.pc);
        compare("accumulator", accumulator, e.ac);
        compare("index_reg", index_reg, e.ix);
        compare("flag_bits", {4'd0, flag_bits}, {4'd0, e.fl});
      end
    end
  end

  always @(negedge clk) begin
    logic quiet;
    quiet = cycle >= QuietStart && cycle < QuietEnd;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) void'(pending.pop_front());
      if (in_valid && !in_fire) begin
        in_valid <= 1'b1;
      end else if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
        in_valid <= 1'b1;
        {kind, mem_addr, mem_wdata, in_data, in_full, out_drained} <= pending[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    logic quiet;
    quiet = cycle >= QuietStart && cycle < QuietEnd;
    if (cycle == HoldStart) hold_left = HoldLen;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 99) < 6;
    end
  end

  initial begin
    logic [7:0] ir;
    int n;
    for (int i = 0; i < acs_pkg::MemBytes; i++) begin
      add_item(acs_pkg::KindWrite, 9'(i), 8'($urandom_range(0, 255)));
    end
    add_item(acs_pkg::KindRead, 9'd0, 8'd0);
    add_item(acs_pkg::KindRead, 9'd511, 8'hff);
    add_item(acs_pkg::KindWrite, 9'h1ff, 8'hff);
    add_insn(8'h00, 8'h00);
    add_insn(8'h62, 8'hff);
    add_insn(8'hb2, 8'h01);
    add_insn(8'h28, 8'h00);
    add_insn(8'h9a, 8'hff);
    add_insn(8'h8a, 8'h01);
    add_insn(8'h10, 8'h00);
    add_insn(8'h18, 8'h00);
    add_insn(8'h20, 8'h00);
    add_insn(8'h41, 8'h00);
    add_insn(8'h45, 8'h00);
    add_insn(8'h4c, 8'h00);
    add_insn(8'h7f, 8'hff);
    add_insn(8'h0a, 8'h40);
    add_insn(8'h0b, 8'h00);
    add_insn(8'h3c, 8'h10);
    add_insn(8'h34, 8'h20);
    n = 0;
    while (n < 20) begin
      case ($urandom_range(0, 9))
        0: add_item(acs_pkg::KindRead, 9'($urandom_range(0, 511)),
                    8'($urandom_range(0, 255)));
        1: add_item(acs_pkg::KindWrite, 9'($urandom_range(0, 511)), pick_byte());
        2: add_item(KindNone, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        default: begin
          do ir = 8'($urandom_range(0, 255)); while (stops_cpu(ir));
          add_insn(ir, pick_byte());
        end
      endcase
      n++;
    end
    case ($urandom_range(0, 3))
      0: ir = 8'h0c;
      1: ir = 8'h09;
      2: ir = 8'h5a;
      default: ir = 8'h72;
    endcase
    add_insn(ir, pick_byte());
    add_insn(8'h62, 8'h11);
    add_item(acs_pkg::KindRead, 9'h100, 8'd0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || expected_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/acs_pkg.sv
hdl/acs_front.sv
hdl/acs_back.sv
hdl/accumulator_cpu_8bit_step_core.sv
tb/accumulator_cpu_8bit_step_core_tb.sv
